FILE: sv/rational_box_downscaler_assert.svh
// Assertion macros for the rational box downscaler.
// Each expects i_clk and i_rst_n in the module that uses it.
`ifndef RATIONAL_BOX_DOWNSCALER_ASSERT_SVH
`define RATIONAL_BOX_DOWNSCALER_ASSERT_SVH
`ifndef SYNTHESIS
`define RBD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define RBD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RBD_ASSERT_IMP(lbl, ante, cons, msg)
`define RBD_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

FILE: sv/rbd_pkg.sv
`default_nettype none
package rbd_pkg;
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_RATIO  = 4096;
    localparam int HEIGHT_CAP = 4096;
    localparam int CFG_W      = 13;
    localparam int SUM_W      = 20;
    localparam int COL_W      = $clog2(MAX_WIDTH + 1);
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);

    localparam logic [CFG_W:0] RATIO_CAP  = (CFG_W + 1)'(MAX_RATIO);
    localparam logic [CFG_W:0] WIDTH_CAP  = (CFG_W + 1)'(MAX_WIDTH);
    localparam logic [CFG_W:0] HEIGHT_LIM = (CFG_W + 1)'(HEIGHT_CAP);

    localparam logic [2:0] CFG_HS = 3'd0;
    localparam logic [2:0] CFG_HT = 3'd1;
    localparam logic [2:0] CFG_VS = 3'd2;
    localparam logic [2:0] CFG_VT = 3'd3;
    localparam logic [2:0] CFG_SW = 3'd4;
    localparam logic [2:0] CFG_SH = 3'd5;
    localparam logic [2:0] CFG_TW = 3'd6;
    localparam logic [2:0] CFG_TH = 3'd7;

    typedef logic [3:0][SUM_W-1:0] t_sum4;
    typedef logic [3:0][7:0]       t_lane4;

    typedef struct packed {
        logic [7:0] pix_blue;
        logic [7:0] pix_green;
        logic [7:0] pix_red;
        logic [7:0] pix_alpha;
    } t_pix;

    typedef struct packed {
        logic [7:0]  out_blue;
        logic [7:0]  out_green;
        logic [7:0]  out_red;
        logic [7:0]  out_alpha;
        logic [11:0] out_col;
        logic [11:0] out_row;
        logic        row_end;
        logic        frame_end;
    } t_res;

    typedef struct packed {
        logic [CFG_W-1:0] hs;
        logic [CFG_W-1:0] ht;
        logic [CFG_W-1:0] vs;
        logic [CFG_W-1:0] vt;
        logic [CFG_W-1:0] sw;
        logic [CFG_W-1:0] sh;
        logic [CFG_W-1:0] tw;
        logic [CFG_W-1:0] th;
    } t_cfg;

    typedef struct packed {
        t_lane4           hpix;
        logic [COL_W-1:0] col;
        logic [11:0]      row;
        logic             cf_zero;
        logic             vfin;
        logic             emit;
        logic [CFG_W-1:0] w_add;
        logic [CFG_W-1:0] w_keep;
        logic             row_end;
        logic             frame_end;
    } t_vitem;

    function automatic logic [CFG_W-1:0] clamp1(logic [CFG_W-1:0] v, logic [CFG_W:0] cap);
        logic [CFG_W-1:0] r;
        if (v == '0) begin
            r = CFG_W'(1);
        end else if ({1'b0, v} > cap) begin
            r = cap[CFG_W-1:0];
        end else begin
            r = v;
        end
        return r;
    endfunction
endpackage
`default_nettype wire

FILE: sv/rbd_ram.sv
`default_nettype none
module rbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: sv/rbd_div.sv
`default_nettype none
module rbd_div (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire rbd_pkg::t_sum4   i_num,
    input  wire logic [12:0]      i_den,
    output logic                  o_busy,
    output logic                  o_done,
    output rbd_pkg::t_lane4       o_quo
);
    import rbd_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    t_sum4                 r_num, n_num;
    logic [3:0][CFG_W-2:0] r_rem, n_rem;
    logic [3:0][CFG_W-1:0] trial;
    logic [STEP_W-1:0]     r_cnt;
    logic [CFG_W-1:0]      r_den;
    logic                  r_done;

    // one quotient bit per lane per cycle, restoring
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            trial[k] = {r_rem[k], r_num[k][SUM_W-1]};
            if (trial[k] >= r_den) begin
                n_rem[k] = (CFG_W - 1)'(trial[k] - r_den);
                n_num[k] = {r_num[k][SUM_W-2:0], 1'b1};
            end else begin
                n_rem[k] = trial[k][CFG_W-2:0];
                n_num[k] = {r_num[k][SUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= STEP_W'(SUM_W);
            r_done <= 1'b0;
            r_num  <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - STEP_W'(1);
            r_done <= (r_cnt == STEP_W'(1));
            r_num  <= n_num;
            r_rem  <= n_rem;
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_done = r_done;
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            o_quo[k] = r_num[k][7:0];
        end
    end
endmodule
`default_nettype wire

FILE: sv/rbd_fifo.sv
`default_nettype none
module rbd_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire rbd_pkg::t_vitem i_item,
    output logic                 o_full,
    input  wire logic            i_pop,
    output rbd_pkg::t_vitem      o_item,
    output logic                 o_empty
);
    import rbd_pkg::*;

    t_vitem            r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QPTR_W:0]   r_cnt;
    logic              do_push, do_pop;

    assign o_full  = (r_cnt == (QPTR_W + 1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + (QPTR_W + 1)'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - (QPTR_W + 1)'(1);
            end
        end
    end
endmodule
`default_nettype wire

FILE: sv/rbd_front.sv
`default_nettype none
`include "rational_box_downscaler_assert.svh"
module rbd_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire rbd_pkg::t_cfg   i_cfg,
    input  wire logic            i_push,
    input  wire rbd_pkg::t_pix   i_pix,
    output logic                 o_full,
    output logic                 o_q_push,
    output rbd_pkg::t_vitem      o_q_item,
    input  wire logic            i_q_full
);
    import rbd_pkg::*;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_DIV  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]       r_state;
    t_sum4            r_rs, n_rs, s_h;
    logic [CFG_W-1:0] r_rfill, n_rfill;
    logic [11:0]      r_in_col, r_in_row, n_in_col, n_in_row;
    logic [COL_W-1:0] r_hcol, n_hcol;
    logic [CFG_W-1:0] r_cfill, n_cfill;
    logic [11:0]      r_vrow, n_vrow;
    t_vitem           r_item, item;

    t_lane4           pix;
    logic [3:0][20:0] p_need, p_carry, p_ht;
    logic [CFG_W-1:0] need, carry, vneed;
    logic             hdone, hvalid, vfin, rowend, frmend, accept, re;
    logic             div_busy, div_done;
    t_lane4           div_quo;

    assign accept = i_push && !o_full;
    assign o_full = (r_state != F_IDLE);
    assign pix    = {i_pix.pix_alpha, i_pix.pix_red, i_pix.pix_green, i_pix.pix_blue};

    always_comb begin
        need   = i_cfg.hs - r_rfill;
        hdone  = (i_cfg.ht >= need);
        carry  = i_cfg.ht - need;
        hvalid = hdone && (32'(r_hcol) < 32'(i_cfg.tw));
        for (int k = 0; k < 4; k++) begin
            p_need[k]  = 21'(pix[k]) * 21'(need);
            p_carry[k] = 21'(pix[k]) * 21'(carry);
            p_ht[k]    = 21'(pix[k]) * 21'(i_cfg.ht);
            s_h[k]     = r_rs[k] + p_need[k][SUM_W-1:0];
            n_rs[k]    = hdone ? p_carry[k][SUM_W-1:0] : (r_rs[k] + p_ht[k][SUM_W-1:0]);
        end
        n_rfill = hdone ? carry : (r_rfill + i_cfg.ht);
        n_hcol  = r_hcol;
        if (hdone && (32'(r_hcol) < MAX_WIDTH)) begin
            n_hcol = r_hcol + COL_W'(1);
        end

        vneed = i_cfg.vs - r_cfill;
        vfin  = (i_cfg.vt >= vneed);
        re    = (32'(r_hcol) == 32'(i_cfg.tw) - 32'd1);
        item.hpix      = '0;
        item.col       = r_hcol;
        item.row       = r_vrow;
        item.cf_zero   = (r_cfill == '0);
        item.vfin      = vfin;
        item.emit      = vfin && ({1'b0, r_vrow} < i_cfg.th);
        item.w_add     = vfin ? vneed : i_cfg.vt;
        item.w_keep    = i_cfg.vt - vneed;
        item.row_end   = re;
        item.frame_end = re && ({1'b0, r_vrow} == i_cfg.th - CFG_W'(1));

        rowend   = ({1'b0, r_in_col} + CFG_W'(1)) >= i_cfg.sw;
        frmend   = ({1'b0, r_in_row} + CFG_W'(1)) >= i_cfg.sh;
        n_cfill  = r_cfill;
        n_vrow   = r_vrow;
        n_in_col = r_in_col + 12'd1;
        n_in_row = r_in_row;
        if (rowend) begin
            // restart the horizontal phase, step the vertical one
            n_rs     = '0;
            n_rfill  = '0;
            n_hcol   = '0;
            n_in_col = '0;
            if (vfin) begin
                n_cfill = i_cfg.vt - vneed;
                if (r_vrow != 12'hFFF) begin
                    n_vrow = r_vrow + 12'd1;
                end
            end else begin
                n_cfill = r_cfill + i_cfg.vt;
            end
            if (frmend) begin
                n_in_row = '0;
                n_vrow   = '0;
                n_cfill  = '0;
            end else begin
                n_in_row = r_in_row + 12'd1;
            end
        end
    end

    rbd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept && hvalid),
        .i_num   (s_h),
        .i_den   (i_cfg.hs),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= F_IDLE;
            r_rs     <= '0;
            r_rfill  <= '0;
            r_in_col <= '0;
            r_in_row <= '0;
            r_hcol   <= '0;
            r_cfill  <= '0;
            r_vrow   <= '0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (accept) begin
                        r_rs     <= n_rs;
                        r_rfill  <= n_rfill;
                        r_in_col <= n_in_col;
                        r_in_row <= n_in_row;
                        r_hcol   <= n_hcol;
                        r_cfill  <= n_cfill;
                        r_vrow   <= n_vrow;
                        if (hvalid) begin
                            r_item  <= item;
                            r_state <= F_DIV;
                        end
                    end
                end
                F_DIV: begin
                    if (div_done) begin
                        r_item.hpix <= div_quo;
                        r_state     <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!i_q_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    assign o_q_push = (r_state == F_PUSH) && !i_q_full;
    assign o_q_item = r_item;

    `RBD_ASSERT_IMP(a_push_room, o_q_push, !i_q_full, "queue word pushed while full")
    `RBD_ASSERT_NXT(a_div_enter, accept && hvalid, r_state == F_DIV, "divide not entered")
    `RBD_ASSERT_IMP(a_div_live, r_state == F_DIV, div_busy || div_done, "divider idle in F_DIV")
endmodule
`default_nettype wire

FILE: sv/rbd_back.sv
`default_nettype none
module rbd_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire rbd_pkg::t_cfg   i_cfg,
    input  wire logic            i_q_empty,
    input  wire rbd_pkg::t_vitem i_q_item,
    output logic                 o_q_pop,
    output logic                 o_empty,
    input  wire logic            i_pop,
    output rbd_pkg::t_res        o_res
);
    import rbd_pkg::*;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_RD   = 3'd1;
    localparam logic [2:0] B_MUL  = 3'd2;
    localparam logic [2:0] B_ADD  = 3'd3;
    localparam logic [2:0] B_DIV  = 3'd4;
    localparam logic [2:0] B_OUT  = 3'd5;

    logic [2:0]       r_state;
    t_vitem           r_it;
    t_sum4            r_prev, r_padd, r_pkeep, s_v, wdata, rdata;
    logic [3:0][20:0] p_add, p_keep;
    t_lane4           r_vpix, div_quo;
    t_res             r_res;
    logic             r_ovalid;
    logic             we, div_start, div_busy, div_done, load_out;

    rbd_ram #(.WIDTH(4 * SUM_W), .DEPTH(MAX_WIDTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_it.col[ADDR_W-1:0]),
        .i_wdata (wdata),
        .i_raddr (r_it.col[ADDR_W-1:0]),
        .o_rdata (rdata)
    );

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            p_add[k]  = 21'(r_it.hpix[k]) * 21'(r_it.w_add);
            p_keep[k] = 21'(r_it.hpix[k]) * 21'(r_it.w_keep);
            s_v[k]    = r_prev[k] + r_padd[k];
            wdata[k]  = r_it.vfin ? r_pkeep[k] : s_v[k];
        end
    end

    assign o_q_pop   = (r_state == B_IDLE) && !i_q_empty;
    assign we        = (r_state == B_ADD);
    assign div_start = (r_state == B_ADD) && r_it.emit;
    assign load_out  = (r_state == B_OUT) && (!r_ovalid || i_pop);

    rbd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (s_v),
        .i_den   (i_cfg.vs),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            unique case (r_state)
                B_IDLE: begin
                    if (!i_q_empty) begin
                        r_it    <= i_q_item;
                        r_state <= B_RD;
                    end
                end
                B_RD:  r_state <= B_MUL;
                B_MUL: begin
                    // an empty vertical phase starts from zero, no read needed
                    for (int k = 0; k < 4; k++) begin
                        r_prev[k]  <= r_it.cf_zero ? '0 : rdata[k];
                        r_padd[k]  <= p_add[k][SUM_W-1:0];
                        r_pkeep[k] <= p_keep[k][SUM_W-1:0];
                    end
                    r_state <= B_ADD;
                end
                B_ADD: r_state <= r_it.emit ? B_DIV : B_IDLE;
                B_DIV: begin
                    if (div_done && !div_busy) begin
                        r_vpix  <= div_quo;
                        r_state <= B_OUT;
                    end
                end
                B_OUT: begin
                    if (load_out) begin
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_pop && r_ovalid) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_res.out_blue  <= r_vpix[0];
            r_res.out_green <= r_vpix[1];
            r_res.out_red   <= r_vpix[2];
            r_res.out_alpha <= r_vpix[3];
            r_res.out_col   <= 12'(r_it.col);
            r_res.out_row   <= r_it.row;
            r_res.row_end   <= r_it.row_end;
            r_res.frame_end <= r_it.frame_end;
        end
    end

    assign o_empty = !r_ovalid;
    assign o_res   = r_res;
endmodule
`default_nettype wire

FILE: sv/rational_box_downscaler.sv
`default_nettype none
// Rational box-filter BGRA downscaler.
// Source pixels are pushed in raster order on i_push / o_full as one t_pix
// word. Results are read like a queue: while o_empty is low o_res holds the
// oldest output pixel with its column, row, row-end and frame-end flags;
// i_pop takes it.
// Ratios and sizes are written through i_cfg_we / i_cfg_idx / i_cfg_data;
// the user must do so only while the block is idle, which the block itself
// does not enforce. All eight registers reset to 1. A pixel that completes
// no horizontal output column is taken while the front end stays idle. One
// that completes a column holds o_full while the 20-step horizontal divider
// in the front end runs and until its word enters the queue. The back end
// reads and rewrites the column line store and, for a word that completes
// an output pixel, runs its own 20-step divider; a 4-word queue sits between
// the two. Reset clears all counters and partial sums; the column store
// needs no clearing pass. If the receiver stalls, the output word holds, the
// back end stops, the queue fills and then o_full stays high.
module rational_box_downscaler (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic [2:0]     i_cfg_idx,
    input  wire logic [12:0]    i_cfg_data,
    input  wire logic           i_push,
    input  wire rbd_pkg::t_pix  i_pix,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_empty,
    output rbd_pkg::t_res       o_res
);
    import rbd_pkg::*;

    logic [CFG_W-1:0] r_cfg [8];
    t_cfg             cfg;
    t_vitem           q_in, q_out;
    logic             q_push, q_full, q_pop, q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 8; k++) begin
                r_cfg[k] <= CFG_W'(1);
            end
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_comb begin
        cfg.hs = clamp1(r_cfg[CFG_HS], RATIO_CAP);
        cfg.ht = clamp1(r_cfg[CFG_HT], {1'b0, cfg.hs});
        cfg.vs = clamp1(r_cfg[CFG_VS], RATIO_CAP);
        cfg.vt = clamp1(r_cfg[CFG_VT], {1'b0, cfg.vs});
        cfg.sw = clamp1(r_cfg[CFG_SW], WIDTH_CAP);
        cfg.sh = clamp1(r_cfg[CFG_SH], HEIGHT_LIM);
        cfg.tw = clamp1(r_cfg[CFG_TW], WIDTH_CAP);
        cfg.th = clamp1(r_cfg[CFG_TH], HEIGHT_LIM);
    end

    rbd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_push   (i_push),
        .i_pix    (i_pix),
        .o_full   (o_full),
        .o_q_push (q_push),
        .o_q_item (q_in),
        .i_q_full (q_full)
    );

    rbd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_item  (q_out),
        .o_empty (q_empty)
    );

    rbd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_empty (q_empty),
        .i_q_item  (q_out),
        .o_q_pop   (q_pop),
        .o_empty   (o_empty),
        .i_pop     (i_pop),
        .o_res     (o_res)
    );
endmodule
`default_nettype wire
